// ===== src/sbs_pkg.sv =====
// shared types, widths and opcodes of the stroke smoother
// no dependencies; imported by every module of the block
package sbs_pkg;

  localparam int COORD_W   = 16;
  localparam int PRE_SHIFT = (COORD_W > 24) ? (COORD_W - 24) : 0;
  localparam int MAG_W     = COORD_W - PRE_SHIFT + 1;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int RAD_W     = 2 * MAG_W + 9;
  localparam int ROOT_W    = MAG_W + 5;
  localparam int GAIN_W    = 8;
  localparam int PG_W      = GAIN_W + ROOT_W;
  localparam int NUM_W     = PG_W + MAG_W;
  localparam int REM_W     = NUM_W + 1;
  localparam int DEN_W     = ROOT_W + 8;
  localparam int DS_W      = DEN_W + ROOT_W - 1;
  localparam int STEP_W    = $clog2(ROOT_W);
  localparam int SUM_W     = COORD_W + ROOT_W + PRE_SHIFT + 2;

  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd64;
  localparam logic REG_GAIN = 1'b0;

  localparam logic [1:0] SEG_BEGIN  = 2'd0;
  localparam logic [1:0] SEG_LINE   = 2'd1;
  localparam logic [1:0] SEG_BEZIER = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   stroke_last;
  } point_t;

  typedef struct packed {
    logic [1:0] seg_kind;
    coord_t     ctrl1_x;
    coord_t     ctrl1_y;
    coord_t     ctrl2_x;
    coord_t     ctrl2_y;
    coord_t     end_x;
    coord_t     end_y;
    logic       stroke_end;
  } segment_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SQA, OP_SQB, OP_RINIT, OP_RSTEP, OP_RSTORE, OP_MULG,
    OP_MULC, OP_DINIT, OP_DSTEP, OP_APPLY, OP_BEGIN, OP_LINE, OP_BEZ, OP_UPDATE
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] count;
    logic       last;
    logic       out_free;
  } dp_status_t;

endpackage

// ===== src/sbs_datapath.sv =====
// history, shared square root and divide units, control point math, output register
// depends on sbs_pkg; driven by sbs_controller
module sbs_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  sbs_pkg::point_t             in_data,
  input  logic [sbs_pkg::GAIN_W-1:0]  gain,
  input  sbs_pkg::dp_cmd_t            cmd,
  output sbs_pkg::dp_status_t         status,
  output sbs_pkg::segment_t           out_data,
  output logic                        out_valid,
  input  logic                        out_stall
);
  import sbs_pkg::*;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((2 ** (COORD_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-(2 ** (COORD_W - 1)));

  coord_t hx [3];
  coord_t hy [3];
  coord_t nx, ny;
  logic last_r;
  logic [1:0] count;
  coord_t ctrl [4];
  logic emit;

  logic [SQ_W-1:0] sq_a, sq_b;
  logic [RAD_W-1:0] rad, res, sbit;
  logic [ROOT_W-1:0] r_e, r_a, r_b;
  logic [PG_W-1:0] prod_g;
  logic [NUM_W-1:0] num;
  logic [REM_W-1:0] rem;
  logic [DS_W-1:0] ds;
  logic [ROOT_W-1:0] quot;

  function automatic logic signed [COORD_W:0] sdiff(input coord_t a, input coord_t b);
    sdiff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [COORD_W:0] d);
    logic [COORD_W:0] m;
    m = d[COORD_W] ? (~d + 1'b1) : d;
    mag_of = m[COORD_W:PRE_SHIFT];
  endfunction

  logic signed [COORD_W:0] ex, ey, ax, ay, bx, by;
  assign ex = sdiff(hx[2], hx[1]);
  assign ey = sdiff(hy[2], hy[1]);
  assign ax = sdiff(hx[2], hx[0]);
  assign ay = sdiff(hy[2], hy[0]);
  assign bx = sdiff(nx, hx[1]);
  assign by = sdiff(ny, hy[1]);

  assign emit = (cmd.op == OP_BEGIN) || (cmd.op == OP_LINE) || (cmd.op == OP_BEZ);

  // norm operand select
  logic [MAG_W-1:0] na, nb;
  always_comb begin
    case (cmd.sel)
      2'd0: begin
        na = mag_of(ex);
        nb = mag_of(ey);
      end
      2'd1: begin
        na = mag_of(ax);
        nb = mag_of(ay);
      end
      default: begin
        na = mag_of(bx);
        nb = mag_of(by);
      end
    endcase
  end

  // offset operand select
  logic signed [COORD_W:0] c_val;
  logic [ROOT_W-1:0] rd;
  logic [MAG_W-1:0] c_mag;
  always_comb begin
    case (cmd.sel)
      2'd0: c_val = ax;
      2'd1: c_val = ay;
      2'd2: c_val = bx;
      default: c_val = by;
    endcase
    rd = cmd.sel[1] ? r_b : r_a;
    c_mag = mag_of(c_val);
  end

  logic [SQ_W-1:0] sq_c;
  logic [PG_W-1:0] pg_c;
  logic [NUM_W-1:0] num_c;
  assign sq_c  = cmd.op == OP_SQA ? na * na : nb * nb;
  assign pg_c  = gain * r_e;
  assign num_c = prod_g * c_mag;

  logic [RAD_W-1:0] root_t;
  assign root_t = res + sbit;

  // control point from quotient
  logic [ROOT_W+PRE_SHIFT-1:0] offm;
  logic signed [SUM_W-1:0] off_u, off_s, base_s, tot;
  coord_t base_c, sat_c;
  always_comb begin
    offm  = (ROOT_W + PRE_SHIFT)'(quot) << PRE_SHIFT;
    off_u = SUM_W'(offm);
    if (c_val == '0 || rd == '0) begin
      off_s = '0;
    end else begin
      off_s = c_val[COORD_W] ? -off_u : off_u;
    end
    case (cmd.sel)
      2'd0: base_c = hx[1];
      2'd1: base_c = hy[1];
      2'd2: base_c = hx[2];
      default: base_c = hy[2];
    endcase
    base_s = SUM_W'(base_c);
    tot = cmd.sel[1] ? base_s - off_s : base_s + off_s;
    if (tot > SAT_MAX) begin
      sat_c = coord_t'(SAT_MAX[COORD_W-1:0]);
    end else if (tot < SAT_MIN) begin
      sat_c = coord_t'(SAT_MIN[COORD_W-1:0]);
    end else begin
      sat_c = tot[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        hx[k] <= '0;
        hy[k] <= '0;
      end
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          nx <= in_data.point_x;
          ny <= in_data.point_y;
          last_r <= in_data.stroke_last;
        end
        OP_SQA: sq_a <= sq_c;
        OP_SQB: sq_b <= sq_c;
        OP_RINIT: begin
          rad <= {(SQ_W + 1)'(sq_a) + (SQ_W + 1)'(sq_b), 8'd0};
          res <= '0;
          sbit <= {1'b1, {(RAD_W - 1){1'b0}}};
        end
        OP_RSTEP: begin
          if (rad >= root_t) begin
            rad <= rad - root_t;
            res <= (res >> 1) + sbit;
          end else begin
            res <= res >> 1;
          end
          sbit <= sbit >> 2;
        end
        OP_RSTORE: begin
          case (cmd.sel)
            2'd0: r_e <= res[ROOT_W-1:0];
            2'd1: r_a <= res[ROOT_W-1:0];
            default: r_b <= res[ROOT_W-1:0];
          endcase
        end
        OP_MULG: prod_g <= pg_c;
        OP_MULC: num <= num_c;
        OP_DINIT: begin
          rem <= REM_W'(num) + REM_W'({rd, 7'd0});
          ds <= {rd, 8'd0, {(ROOT_W - 1){1'b0}}};
          quot <= '0;
        end
        OP_DSTEP: begin
          if ({{(DS_W - REM_W){1'b0}}, rem} >= ds) begin
            rem <= rem - ds[REM_W-1:0];
            quot <= {quot[ROOT_W-2:0], 1'b1};
          end else begin
            quot <= {quot[ROOT_W-2:0], 1'b0};
          end
          ds <= ds >> 1;
        end
        OP_APPLY: ctrl[cmd.sel] <= sat_c;
        OP_BEGIN, OP_LINE: begin
          out_data <= '{seg_kind: (cmd.op == OP_BEGIN) ? SEG_BEGIN : SEG_LINE,
                        ctrl1_x: '0, ctrl1_y: '0, ctrl2_x: '0, ctrl2_y: '0,
                        end_x: nx, end_y: ny, stroke_end: last_r};
        end
        OP_BEZ: begin
          out_data <= '{seg_kind: SEG_BEZIER,
                        ctrl1_x: ctrl[0], ctrl1_y: ctrl[1],
                        ctrl2_x: ctrl[2], ctrl2_y: ctrl[3],
                        end_x: hx[2], end_y: hy[2], stroke_end: 1'b0};
        end
        OP_UPDATE: begin
          hx[0] <= hx[1];
          hy[0] <= hy[1];
          hx[1] <= hx[2];
          hy[1] <= hy[2];
          hx[2] <= nx;
          hy[2] <= ny;
          if (last_r) begin
            count <= '0;
          end else if (count != 2'd3) begin
            count <= count + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign status = '{count: count, last: last_r, out_free: !out_valid || !out_stall};

endmodule

// ===== src/sbs_controller.sv =====
// sequencer for the stroke smoother: dispatch, norms, offsets, emits
// depends on sbs_pkg; commands sbs_datapath
module sbs_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sbs_pkg::dp_status_t status,
  output sbs_pkg::dp_cmd_t    cmd
);
  import sbs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SQA, S_SQB, S_RINIT, S_RSTEP, S_RSTORE, S_MULG,
    S_MULC, S_DINIT, S_DSTEP, S_APPLY, S_BEGIN, S_LINE, S_BEZ, S_UPDATE
  } state_t;

  state_t state;
  logic [STEP_W-1:0] step;
  logic [1:0] idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DISPATCH;
        end
        S_DISPATCH: begin
          idx <= '0;
          case (status.count)
            2'd0: state <= S_BEGIN;
            2'd1: state <= S_LINE;
            2'd2: state <= status.last ? S_LINE : S_UPDATE;
            default: state <= S_SQA;
          endcase
        end
        S_SQA: state <= S_SQB;
        S_SQB: state <= S_RINIT;
        S_RINIT: begin
          step <= '0;
          state <= S_RSTEP;
        end
        S_RSTEP: begin
          step <= step + 1'b1;
          if (step == STEP_W'(ROOT_W - 1)) state <= S_RSTORE;
        end
        S_RSTORE: begin
          if (idx == 2'd2) begin
            idx <= '0;
            state <= S_MULG;
          end else begin
            idx <= idx + 2'd1;
            state <= S_SQA;
          end
        end
        S_MULG: state <= S_MULC;
        S_MULC: state <= S_DINIT;
        S_DINIT: begin
          step <= '0;
          state <= S_DSTEP;
        end
        S_DSTEP: begin
          step <= step + 1'b1;
          if (step == STEP_W'(ROOT_W - 1)) state <= S_APPLY;
        end
        S_APPLY: begin
          idx <= idx + 2'd1;
          state <= (idx == 2'd3) ? S_BEZ : S_MULC;
        end
        S_BEGIN, S_LINE: begin
          if (status.out_free) state <= S_UPDATE;
        end
        S_BEZ: begin
          if (status.out_free) state <= status.last ? S_LINE : S_UPDATE;
        end
        S_UPDATE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.sel = idx;
    case (state)
      S_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_SQA:    cmd.op = OP_SQA;
      S_SQB:    cmd.op = OP_SQB;
      S_RINIT:  cmd.op = OP_RINIT;
      S_RSTEP:  cmd.op = OP_RSTEP;
      S_RSTORE: cmd.op = OP_RSTORE;
      S_MULG:   cmd.op = OP_MULG;
      S_MULC:   cmd.op = OP_MULC;
      S_DINIT:  cmd.op = OP_DINIT;
      S_DSTEP:  cmd.op = OP_DSTEP;
      S_APPLY:  cmd.op = OP_APPLY;
      S_BEGIN:  cmd.op = status.out_free ? OP_BEGIN : OP_NONE;
      S_LINE:   cmd.op = status.out_free ? OP_LINE : OP_NONE;
      S_BEZ:    cmd.op = status.out_free ? OP_BEZ : OP_NONE;
      S_UPDATE: cmd.op = OP_UPDATE;
      default:  cmd.op = OP_NONE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_BEGIN || cmd.op == OP_LINE || cmd.op == OP_BEZ) |-> status.out_free)
    else $error("emit while output register busy");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RSTEP || state == S_DSTEP) |-> step < STEP_W'(ROOT_W))
    else $error("iteration count out of range");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == S_DISPATCH)
    else $error("accepted transfer not dispatched");

  a_bez_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQA) |-> status.count == 2'd3)
    else $error("curve work without full history");

endmodule

// ===== src/stroke_bezier_smoother_top.sv =====
// stroke smoother top level: apb gain register, sequencer and datapath
// depends on sbs_pkg, sbs_controller, sbs_datapath
// a begin or line result is registered in its emit state once the output register is free; a
// curve result follows three 22-step root and four 22-step divide passes, run one at a time on
// the bit-serial root and divide units; input is taken again only in idle, after the update
// that follows the last result, so a new point waits until the last is done; sync reset
module stroke_bezier_smoother_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sbs_pkg::point_t             in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sbs_pkg::segment_t           out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sbs_pkg::ADDR_W-1:0]  paddr,
  input  logic [sbs_pkg::DATA_W-1:0]  pwdata,
  output logic [sbs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import sbs_pkg::*;

  logic [GAIN_W-1:0] gain;
  dp_cmd_t cmd;
  dp_status_t status;

  assign pready = 1'b1;

  // reset: new stroke, history zero, gain 64
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_GAIN) begin
      gain <= pwdata[GAIN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_GAIN) ? DATA_W'(gain) : '0;

  sbs_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sbs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .gain      (gain),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule
